>>> sv/triangle_plane_slicer_defines.svh
// Assertion macros for the triangle plane slicer RTL.
// Included by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef TRIANGLE_PLANE_SLICER_DEFINES_SVH
`define TRIANGLE_PLANE_SLICER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("triangle plane slicer check failed");

// Next-cycle implication, disabled during reset.
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("triangle plane slicer check failed");

`endif

>>> sv/tps_pkg.sv
// Shared types, constants and helper functions of the triangle plane slicer.
// No dependencies; used by tps_ifs, tps_geom, tps_table and the top level.
`default_nettype none

package tps_pkg;

  localparam int ORIGIN_W   = 32;
  localparam int NORM_W     = 18;
  localparam int TOL_W      = 20;
  localparam int FRAC_W     = 16;
  localparam int MAG_W      = 49;
  localparam int DEN_W      = MAG_W + 1;
  localparam int CHUNK_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd6;

  localparam logic OP_SLICE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Endpoint candidates in priority order.
  localparam logic [2:0] CAND_VA      = 3'd0;
  localparam logic [2:0] CAND_VB      = 3'd1;
  localparam logic [2:0] CAND_VC      = 3'd2;
  localparam logic [2:0] CAND_EDGE_AB = 3'd3;
  localparam logic [2:0] CAND_EDGE_BC = 3'd4;
  localparam logic [2:0] CAND_EDGE_AC = 3'd5;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_STORED = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic start;
    logic clear;
  } tbl_req_t;

  typedef struct packed {
    logic    done;
    status_e status;
  } tbl_rsp_t;

  typedef struct packed {
    logic done;
    logic have_seg;
  } geo_rsp_t;

  function automatic logic [1:0] edge_first(input logic [2:0] code);
    logic [1:0] r;
    case (code)
      CAND_EDGE_AB: r = 2'd0;
      CAND_EDGE_BC: r = 2'd1;
      CAND_EDGE_AC: r = 2'd0;
      default:      r = code[1:0];
    endcase
    return r;
  endfunction

  function automatic logic [1:0] edge_second(input logic [2:0] code);
    logic [1:0] r;
    case (code)
      CAND_EDGE_AB: r = 2'd1;
      CAND_EDGE_BC: r = 2'd2;
      CAND_EDGE_AC: r = 2'd2;
      default:      r = code[1:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/tps_ifs.sv
// Channel interfaces of the triangle plane slicer: triangle input, segment result, config write.
// Depends on tps_pkg for configuration port widths.
`default_nettype none

interface tps_tri_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_a_z;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_b_z;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;
  logic signed [COORD_BITS-1:0] vertex_c_z;

  modport source (output valid, operation, vertex_a_x, vertex_a_y, vertex_a_z,
                  vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  input ready);
  modport sink (input valid, operation, vertex_a_x, vertex_a_y, vertex_a_z,
                vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                output ready);
endinterface

interface tps_seg_if #(parameter int COORD_BITS = 32, parameter int COUNT_W = 11);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;
  logic [COUNT_W-1:0]           stored_count;

  modport source (output valid, status, start_x, start_y, start_z, end_x, end_y, end_z,
                  stored_count, input ready);
  modport sink (input valid, status, start_x, start_y, start_z, end_x, end_y, end_z,
                stored_count, output ready);
endinterface

interface tps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tps_pkg::CFG_IDX_W-1:0]  index;
  logic [tps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/triangle_plane_slicer.sv
// Top level of the triangle plane slicer: configuration registers, control and result register.
// Depends on tps_pkg, tps_ifs, tps_geom, tps_table and the assertion macro header.
//
//  channel  | modport | transaction
//  ---------+---------+------------------------------------------------
//  tri_i    | sink    | one triangle to slice, or a table clear
//  seg_o    | source  | status, segment endpoints and stored count
//  cfg_i    | sink    | one register write (index, data), always ready
//
// A slice computes the three plane distances, copies each on-plane endpoint coordinate and
// finds each crossing coordinate with the shared multiplier and the bit-serial divider; the
// duplicate scan then reads the segment memory at one entry per cycle.
// Reset empties the table at once; memory contents are never cleared.
// A result waiting on seg_o holds the block only until the next result is ready.
`default_nettype none
`include "triangle_plane_slicer_defines.svh"

module triangle_plane_slicer #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tps_tri_if.sink   tri_i,
  tps_seg_if.source seg_o,
  tps_cfg_if.sink   cfg_i
);

  localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W   = 6 * COORD_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GEOM = 2'd1;
  localparam logic [1:0] S_TBL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                             state_q, state_d;
  logic signed [tps_pkg::ORIGIN_W-1:0]    origin_q [3];
  logic signed [tps_pkg::NORM_W-1:0]      normal_q [3];
  logic [tps_pkg::TOL_W-1:0]              tol_q;
  tps_pkg::status_e                       res_st_q, res_st_d;
  logic                                   have_q, have_d;
  logic                                   ovalid_q, ovalid_d;
  tps_pkg::status_e                       ost_q, ost_d;
  logic [ENT_W-1:0]                       opts_q, opts_d;
  logic [COUNT_W-1:0]                     ocnt_q, ocnt_d;

  logic signed [COORD_BITS-1:0]           vtx [3][3];
  logic                                   in_acc, geo_start, out_free;
  tps_pkg::geo_rsp_t                      geo_rsp;
  tps_pkg::tbl_req_t                      tbl_req;
  tps_pkg::tbl_rsp_t                      tbl_rsp;
  logic [ENT_W-1:0]                       seg_pts;
  logic [COUNT_W-1:0]                     tbl_count;

  assign vtx[0][0] = tri_i.vertex_a_x;
  assign vtx[0][1] = tri_i.vertex_a_y;
  assign vtx[0][2] = tri_i.vertex_a_z;
  assign vtx[1][0] = tri_i.vertex_b_x;
  assign vtx[1][1] = tri_i.vertex_b_y;
  assign vtx[1][2] = tri_i.vertex_b_z;
  assign vtx[2][0] = tri_i.vertex_c_x;
  assign vtx[2][1] = tri_i.vertex_c_y;
  assign vtx[2][2] = tri_i.vertex_c_z;

  assign tri_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign in_acc        = tri_i.valid && tri_i.ready;
  assign geo_start     = in_acc && (tri_i.operation == tps_pkg::OP_SLICE);
  assign tbl_req.clear = in_acc && (tri_i.operation == tps_pkg::OP_CLEAR);
  assign tbl_req.start = (state_q == S_GEOM) && geo_rsp.done && geo_rsp.have_seg;
  assign out_free      = !ovalid_q || seg_o.ready;

  always_comb begin
    state_d  = state_q;
    res_st_d = res_st_q;
    have_d   = have_q;
    ovalid_d = ovalid_q && !seg_o.ready;
    ost_d    = ost_q;
    opts_d   = opts_q;
    ocnt_d   = ocnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_st_d = tps_pkg::ST_NONE;
          have_d   = 1'b0;
          state_d  = tbl_req.clear ? S_OUT : S_GEOM;
        end
      end
      S_GEOM: begin
        if (geo_rsp.done) begin
          have_d  = geo_rsp.have_seg;
          state_d = geo_rsp.have_seg ? S_TBL : S_OUT;
        end
      end
      S_TBL: begin
        if (tbl_rsp.done) begin
          res_st_d = tbl_rsp.status;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ost_d    = res_st_q;
          opts_d   = have_q ? seg_pts : '0;
          ocnt_d   = tbl_count;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_st_q    <= tps_pkg::ST_NONE;
      have_q      <= 1'b0;
      ovalid_q    <= 1'b0;
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= tps_pkg::NORM_W'(1 << tps_pkg::FRAC_W);
      tol_q       <= tps_pkg::TOL_W'(10);
    end else begin
      state_q  <= state_d;
      res_st_q <= res_st_d;
      have_q   <= have_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          tps_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_i.data;
          tps_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_i.data;
          tps_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_i.data;
          tps_pkg::REG_NORMAL_X: normal_q[0] <= cfg_i.data[tps_pkg::NORM_W-1:0];
          tps_pkg::REG_NORMAL_Y: normal_q[1] <= cfg_i.data[tps_pkg::NORM_W-1:0];
          tps_pkg::REG_NORMAL_Z: normal_q[2] <= cfg_i.data[tps_pkg::NORM_W-1:0];
          tps_pkg::REG_TOL:      tol_q       <= cfg_i.data[tps_pkg::TOL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q  <= ost_d;
    opts_q <= opts_d;
    ocnt_q <= ocnt_d;
  end

  tps_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (geo_start),
    .vtx_i     (vtx),
    .origin_i  (origin_q),
    .normal_i  (normal_q),
    .tol_i     (tol_q),
    .rsp_o     (geo_rsp),
    .seg_pts_o (seg_pts)
  );

  tps_table #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .seg_i   (seg_pts),
    .rsp_o   (tbl_rsp),
    .count_o (tbl_count)
  );

  assign seg_o.valid        = ovalid_q;
  assign seg_o.status       = ost_q;
  assign seg_o.start_x      = opts_q[6*COORD_BITS-1 -: COORD_BITS];
  assign seg_o.start_y      = opts_q[5*COORD_BITS-1 -: COORD_BITS];
  assign seg_o.start_z      = opts_q[4*COORD_BITS-1 -: COORD_BITS];
  assign seg_o.end_x        = opts_q[3*COORD_BITS-1 -: COORD_BITS];
  assign seg_o.end_y        = opts_q[2*COORD_BITS-1 -: COORD_BITS];
  assign seg_o.end_z        = opts_q[COORD_BITS-1 -: COORD_BITS];
  assign seg_o.stored_count = ocnt_q;

  `TPS_ASSERT(a_geo_done_state, geo_rsp.done, state_q == S_GEOM)
  `TPS_ASSERT(a_tbl_done_state, tbl_rsp.done, state_q == S_TBL)
  `TPS_ASSERT(a_none_zero, ovalid_q && ost_q == tps_pkg::ST_NONE, opts_q == '0)
  `TPS_ASSERT_NEXT(a_clear_empties, tbl_req.clear, tbl_count == '0)

endmodule

`default_nettype wire

>>> sv/tps_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// The caller guarantees num / den < 2**Q_W; no package dependency.
`default_nettype none

module tps_div #(
  parameter int Q_W   = 33,
  parameter int DEN_W = 50
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [Q_W+DEN_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]       den_i,
  output logic                        done_o,
  output logic [Q_W-1:0]              quot_o,
  output logic [DEN_W-1:0]            rem_o
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [Q_W-1:0]     lo_q, lo_d;
  logic [DEN_W:0]     trial;
  logic               take;

  always_comb begin
    trial  = {rem_q, lo_q[Q_W-1]};
    take   = trial >= {1'b0, den_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(Q_W);
      rem_d  = num_i[Q_W+DEN_W-1:Q_W];
      lo_d   = num_i[Q_W-1:0];
    end else if (busy_q) begin
      rem_d = take ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
      lo_d  = {lo_q[Q_W-2:0], take};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
  end

  assign done_o = done_q;
  assign quot_o = lo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> sv/tps_geom.sv
// Plane distance, endpoint selection and edge crossing sequencer over one shared multiplier.
// Depends on tps_pkg and tps_div.
`default_nettype none

module tps_geom #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [COORD_BITS-1:0]         vtx_i [3][3],
  input  wire logic signed [tps_pkg::ORIGIN_W-1:0]  origin_i [3],
  input  wire logic signed [tps_pkg::NORM_W-1:0]    normal_i [3],
  input  wire logic [tps_pkg::TOL_W-1:0]            tol_i,
  output tps_pkg::geo_rsp_t                         rsp_o,
  output logic [6*COORD_BITS-1:0]                   seg_pts_o
);

  localparam int X_W   = ((COORD_BITS > tps_pkg::ORIGIN_W) ? COORD_BITS : tps_pkg::ORIGIN_W) + 1;
  localparam int P_W   = X_W + tps_pkg::NORM_W;
  localparam int A_W   = 3 * tps_pkg::CHUNK_W;
  localparam int ACC_W = X_W + A_W;
  localparam int NUM_W = X_W + tps_pkg::DEN_W;
  localparam int MAG_W = tps_pkg::MAG_W;
  localparam int DEN_W = tps_pkg::DEN_W;

  localparam logic [3:0] G_IDLE = 4'd0;
  localparam logic [3:0] G_DMUL = 4'd1;
  localparam logic [3:0] G_DACC = 4'd2;
  localparam logic [3:0] G_DFIN = 4'd3;
  localparam logic [3:0] G_PICK = 4'd4;
  localparam logic [3:0] G_PT   = 4'd5;
  localparam logic [3:0] G_LMUL = 4'd6;
  localparam logic [3:0] G_LACC = 4'd7;
  localparam logic [3:0] G_DST  = 4'd8;
  localparam logic [3:0] G_DIV  = 4'd9;
  localparam logic [3:0] G_LFIN = 4'd10;
  localparam logic [3:0] G_DONE = 4'd11;

  logic [3:0]                    state_q, state_d;
  logic [1:0]                    vi_q, vi_d, ax_q, ax_d, chunk_q, chunk_d;
  logic                          slot_q, slot_d;
  logic signed [COORD_BITS-1:0]  v_q [3][3];
  logic signed [COORD_BITS-1:0]  v_d [3][3];
  logic [MAG_W-1:0]              mag_q [3];
  logic [MAG_W-1:0]              mag_d [3];
  logic [2:0]                    neg_q, neg_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [P_W-1:0]         prod_q, prod_d;
  logic [2:0]                    code_q [2];
  logic [2:0]                    code_d [2];
  logic signed [COORD_BITS-1:0]  pt_q [2][3];
  logic signed [COORD_BITS-1:0]  pt_d [2][3];
  logic                          have_q, have_d;

  logic signed [X_W-1:0]         dx, dv, x_op, p1_x, res_x;
  logic [X_W-1:0]                dvmag;
  logic                          dvneg;
  logic signed [tps_pkg::NORM_W-1:0] y_op;
  logic signed [P_W-1:0]         mul_p;
  logic [2:0]                    cur_code;
  logic [1:0]                    ep, eq;
  logic signed [COORD_BITS-1:0]  p1, p2;
  logic [A_W-1:0]                a_ext;
  logic [DEN_W-1:0]              den;
  logic signed [63:0]            s64;
  logic [63:0]                   m64;
  logic [MAG_W-1:0]              dmag;
  logic [2:0]                    z;
  logic [5:0]                    ok;
  logic [2:0]                    sel [2];
  logic [1:0]                    n;
  logic                          div_start, div_done, rnd;
  logic [X_W-1:0]                quot, qr;
  logic [DEN_W-1:0]              rem;
  logic [3:0]                    adv_state;
  logic [1:0]                    adv_ax;
  logic                          adv_slot;

  always_comb begin
    cur_code = code_q[slot_q];
    ep       = tps_pkg::edge_first(cur_code);
    eq       = tps_pkg::edge_second(cur_code);
    p1       = v_q[ep][ax_q];
    p2       = v_q[eq][ax_q];
    p1_x     = X_W'(p1);
    dv       = X_W'(p2) - p1_x;
    dvneg    = dv[X_W-1];
    dvmag    = dvneg ? X_W'(-dv) : X_W'(dv);
    a_ext    = A_W'(mag_q[ep]);
    den      = DEN_W'(mag_q[ep]) + DEN_W'(mag_q[eq]);
    dx       = X_W'(v_q[vi_q][ax_q]) - X_W'(origin_i[ax_q]);
    if (state_q == G_LMUL) begin
      x_op = dvmag;
      y_op = signed'({1'b0, a_ext[chunk_q*tps_pkg::CHUNK_W +: tps_pkg::CHUNK_W]});
    end else begin
      x_op = dx;
      y_op = normal_i[ax_q];
    end
    mul_p = x_op * y_op;

    s64  = 64'(acc_q);
    m64  = s64[63] ? 64'(-s64) : 64'(s64);
    dmag = MAG_W'(m64[63:tps_pkg::FRAC_W]) + MAG_W'(m64[tps_pkg::FRAC_W-1]);

    for (int i = 0; i < 3; i++) begin
      z[i] = mag_q[i] <= MAG_W'(tol_i);
    end
    ok[0] = z[0];
    ok[1] = z[1];
    ok[2] = z[2];
    ok[3] = !z[0] && !z[1] && (neg_q[0] != neg_q[1]);
    ok[4] = !z[1] && !z[2] && (neg_q[1] != neg_q[2]);
    ok[5] = !z[0] && !z[2] && (neg_q[0] != neg_q[2]);
    n      = 2'd0;
    sel[0] = tps_pkg::CAND_VA;
    sel[1] = tps_pkg::CAND_VA;
    for (int c = 0; c < 6; c++) begin
      if (ok[c] && n < 2'd2) begin
        sel[n[0]] = 3'(c);
        n         = n + 2'd1;
      end
    end

    rnd   = {rem, 1'b0} >= {1'b0, den};
    qr    = quot + X_W'(rnd);
    res_x = dvneg ? p1_x - signed'(qr) : p1_x + signed'(qr);

    adv_ax    = (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
    adv_slot  = (ax_q == 2'd2) ? 1'b1 : slot_q;
    adv_state = (ax_q == 2'd2 && slot_q) ? G_DONE : G_PT;
  end

  always_comb begin
    state_d   = state_q;
    vi_d      = vi_q;
    ax_d      = ax_q;
    chunk_d   = chunk_q;
    slot_d    = slot_q;
    v_d       = v_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    code_d    = code_q;
    pt_d      = pt_q;
    have_d    = have_q;
    div_start = 1'b0;
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          v_d     = vtx_i;
          vi_d    = 2'd0;
          ax_d    = 2'd0;
          acc_d   = '0;
          state_d = G_DMUL;
        end
      end
      G_DMUL: begin
        prod_d  = mul_p;
        state_d = G_DACC;
      end
      G_DACC: begin
        acc_d = acc_q + ACC_W'(prod_q);
        if (ax_q == 2'd2) begin
          state_d = G_DFIN;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = G_DMUL;
        end
      end
      G_DFIN: begin
        mag_d[vi_q] = dmag;
        neg_d[vi_q] = s64[63];
        acc_d       = '0;
        ax_d        = 2'd0;
        if (vi_q == 2'd2) begin
          state_d = G_PICK;
        end else begin
          vi_d    = vi_q + 2'd1;
          state_d = G_DMUL;
        end
      end
      G_PICK: begin
        if (!(&z) && n == 2'd2) begin
          code_d  = sel;
          slot_d  = 1'b0;
          ax_d    = 2'd0;
          have_d  = 1'b1;
          state_d = G_PT;
        end else begin
          have_d  = 1'b0;
          state_d = G_DONE;
        end
      end
      G_PT: begin
        if (cur_code < tps_pkg::CAND_EDGE_AB) begin
          pt_d[slot_q][ax_q] = v_q[cur_code[1:0]][ax_q];
          ax_d    = adv_ax;
          slot_d  = adv_slot;
          state_d = adv_state;
        end else begin
          chunk_d = 2'd2;
          acc_d   = '0;
          state_d = G_LMUL;
        end
      end
      G_LMUL: begin
        prod_d  = mul_p;
        state_d = G_LACC;
      end
      G_LACC: begin
        acc_d = (acc_q <<< tps_pkg::CHUNK_W) + ACC_W'(prod_q);
        if (chunk_q == 2'd0) begin
          state_d = G_DST;
        end else begin
          chunk_d = chunk_q - 2'd1;
          state_d = G_LMUL;
        end
      end
      G_DST: begin
        div_start = 1'b1;
        state_d   = G_DIV;
      end
      G_DIV: begin
        if (div_done) begin
          state_d = G_LFIN;
        end
      end
      G_LFIN: begin
        pt_d[slot_q][ax_q] = res_x[COORD_BITS-1:0];
        ax_d    = adv_ax;
        slot_d  = adv_slot;
        state_d = adv_state;
      end
      G_DONE: begin
        state_d = G_IDLE;
      end
      default: begin
        state_d = G_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      vi_q    <= '0;
      ax_q    <= '0;
      chunk_q <= '0;
      slot_q  <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vi_q    <= vi_d;
      ax_q    <= ax_d;
      chunk_q <= chunk_d;
      slot_q  <= slot_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    code_q <= code_d;
    pt_q   <= pt_d;
  end

  tps_div #(
    .Q_W   (X_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q[NUM_W-1:0]),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  assign rsp_o.done     = (state_q == G_DONE);
  assign rsp_o.have_seg = have_q;
  assign seg_pts_o      = {pt_q[0][0], pt_q[0][1], pt_q[0][2],
                           pt_q[1][0], pt_q[1][1], pt_q[1][2]};

endmodule

`default_nettype wire

>>> sv/tps_table.sv
// Segment table: one synchronous memory, a pipelined duplicate scan and the append write.
// Depends on tps_pkg and the assertion macro header.
`default_nettype none
`include "triangle_plane_slicer_defines.svh"

module tps_table #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tps_pkg::tbl_req_t                 req_i,
  input  wire logic [6*COORD_BITS-1:0]           seg_i,
  output tps_pkg::tbl_rsp_t                      rsp_o,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]      count_o
);

  localparam int ENT_W   = 6 * COORD_BITS;
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_SCAN = 2'd1;
  localparam logic [1:0] T_DONE = 2'd2;

  logic [ENT_W-1:0]    mem [MAX_SEGMENTS];
  logic [ENT_W-1:0]    rdata_q;
  logic [ENT_W-1:0]    rev;
  logic [1:0]          state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d, rd_ptr_q, rd_ptr_d;
  logic                pend_q, pend_d;
  tps_pkg::status_e    st_q, st_d;
  logic                rd_en, wr_en, hit;

  assign rev   = {seg_i[3*COORD_BITS-1:0], seg_i[ENT_W-1:3*COORD_BITS]};
  assign rd_en = (state_q == T_SCAN) && (rd_ptr_q < count_q);
  assign hit   = pend_q && (rdata_q == seg_i || rdata_q == rev);
  assign wr_en = (state_q == T_SCAN) && !hit && !rd_en && !pend_q &&
                 (count_q < COUNT_W'(MAX_SEGMENTS));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    pend_d   = 1'b0;
    st_d     = st_q;
    case (state_q)
      T_IDLE: begin
        if (req_i.clear) begin
          count_d = '0;
        end else if (req_i.start) begin
          rd_ptr_d = '0;
          state_d  = T_SCAN;
        end
      end
      T_SCAN: begin
        pend_d = rd_en;
        if (rd_en) begin
          rd_ptr_d = rd_ptr_q + COUNT_W'(1);
        end
        if (hit) begin
          st_d    = tps_pkg::ST_DUP;
          state_d = T_DONE;
        end else if (!rd_en && !pend_q) begin
          if (wr_en) begin
            count_d = count_q + COUNT_W'(1);
            st_d    = tps_pkg::ST_STORED;
          end else begin
            st_d    = tps_pkg::ST_FULL;
          end
          state_d = T_DONE;
        end
      end
      T_DONE: begin
        state_d = T_IDLE;
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      st_q     <= tps_pkg::ST_NONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      st_q     <= st_d;
    end
  end

  // The append write happens only after the scan has drained, so reads never overlap it.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IDX_W-1:0]] <= seg_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_ptr_q[IDX_W-1:0]];
    end
  end

  assign rsp_o.done   = (state_q == T_DONE);
  assign rsp_o.status = st_q;
  assign count_o      = count_q;

  `TPS_ASSERT(a_count_bound, 1'b1, count_q <= COUNT_W'(MAX_SEGMENTS))
  `TPS_ASSERT(a_read_below_count, rd_en, rd_ptr_q < count_q)
  `TPS_ASSERT_NEXT(a_store_counts, wr_en, count_q == $past(count_q) + COUNT_W'(1))
  `TPS_ASSERT(a_write_no_pending, wr_en, !pend_q && !hit)

endmodule

`default_nettype wire

>>> verif/tps_checker.sv
// Checker of the triangle plane slicer: watches the triangle, segment and config channels,
// predicts each result and compares it. Depends on tps_pkg and the interfaces in tps_ifs.
`default_nettype none

module tps_checker #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tps_tri_if        tri_m,
  tps_seg_if        seg_m,
  tps_cfg_if        cfg_m,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tps_pkg::status_e  status;
    logic [5:0][31:0]  pts;
    logic [10:0]       count;
  } seg_result_t;

  logic [31:0]  origin [3];
  logic [17:0]  normal [3];
  logic [19:0]  tol;
  logic [191:0] seg_table [MAX_SEGMENTS];
  int           seg_count;
  seg_result_t  expected_q [$];
  int           mismatches;

  function automatic logic [63:0] sx64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] plane_distance(input logic [31:0] x, y, z,
                                                 output logic neg);
    logic [63:0] s;
    logic [63:0] m;
    s = (sx64(x) - sx64(origin[0])) * {{46{normal[0][17]}}, normal[0]}
      + (sx64(y) - sx64(origin[1])) * {{46{normal[1][17]}}, normal[1]}
      + (sx64(z) - sx64(origin[2])) * {{46{normal[2][17]}}, normal[2]};
    neg = s[63];
    m = neg ? -s : s;
    return (m >> tps_pkg::FRAC_W) + {63'd0, m[tps_pkg::FRAC_W-1]};
  endfunction

  function automatic logic [31:0] crossing_coord(input logic [31:0] p1, p2,
                                                 input logic [63:0] a, b);
    logic [63:0]  dv;
    logic [63:0]  mg;
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    logic         neg;
    dv = sx64(p2) - sx64(p1);
    neg = dv[63];
    mg = neg ? -dv : dv;
    den = {64'd0, a} + {64'd0, b};
    if (den == 0) return p1;
    num = {64'd0, mg} * {64'd0, a};
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return neg ? p1 - q[31:0] : p1 + q[31:0];
  endfunction

  function automatic seg_result_t slice_triangle(input logic [31:0] v [9]);
    seg_result_t res;
    logic [63:0] mag [3];
    logic        neg;
    int          sgn [3];
    logic [95:0] pt [2];
    int          npt;
    int          p;
    int          q;
    logic        dup;
    res = '0;
    npt = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = plane_distance(v[3*i], v[3*i+1], v[3*i+2], neg);
      sgn[i] = (mag[i] <= {44'd0, tol}) ? 0 : (neg ? -1 : 1);
    end
    if (sgn[0] != 0 || sgn[1] != 0 || sgn[2] != 0) begin
      for (int i = 0; i < 3; i++) begin
        if (npt < 2 && sgn[i] == 0) begin
          pt[npt] = {v[3*i], v[3*i+1], v[3*i+2]};
          npt++;
        end
      end
      for (int e = 0; e < 3; e++) begin
        p = (e == 1) ? 1 : 0;
        q = (e == 0) ? 1 : 2;
        if (npt < 2 && sgn[p] != 0 && sgn[q] != 0 && sgn[p] != sgn[q]) begin
          pt[npt] = {crossing_coord(v[3*p], v[3*q], mag[p], mag[q]),
                     crossing_coord(v[3*p+1], v[3*q+1], mag[p], mag[q]),
                     crossing_coord(v[3*p+2], v[3*q+2], mag[p], mag[q])};
          npt++;
        end
      end
    end
    if (npt == 2) begin
      dup = 1'b0;
      for (int j = 0; j < seg_count; j++) begin
        if (seg_table[j] == {pt[0], pt[1]} || seg_table[j] == {pt[1], pt[0]}) dup = 1'b1;
      end
      if (dup) begin
        res.status = tps_pkg::ST_DUP;
      end else if (seg_count >= MAX_SEGMENTS) begin
        res.status = tps_pkg::ST_FULL;
      end else begin
        seg_table[seg_count] = {pt[0], pt[1]};
        seg_count++;
        res.status = tps_pkg::ST_STORED;
      end
      res.pts = {pt[0], pt[1]};
    end
    res.count = seg_count[10:0];
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] exp_v, act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: segment %s expected %0h, got %0h", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seg_result_t exp_r;
    seg_result_t act_r;
    logic [31:0] verts [9];
    string       names [6];
    if (!rst_ni) begin
      origin = '{32'd0, 32'd0, 32'd0};
      normal = '{18'd0, 18'd0, 18'd65536};
      tol = 20'd10;
      seg_count = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      names = '{"start_x", "start_y", "start_z", "end_x", "end_y", "end_z"};
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          tps_pkg::REG_ORIGIN_X: origin[0] = cfg_m.data;
          tps_pkg::REG_ORIGIN_Y: origin[1] = cfg_m.data;
          tps_pkg::REG_ORIGIN_Z: origin[2] = cfg_m.data;
          tps_pkg::REG_NORMAL_X: normal[0] = cfg_m.data[17:0];
          tps_pkg::REG_NORMAL_Y: normal[1] = cfg_m.data[17:0];
          tps_pkg::REG_NORMAL_Z: normal[2] = cfg_m.data[17:0];
          tps_pkg::REG_TOL:      tol = cfg_m.data[19:0];
          default: ;
        endcase
      end
      if (seg_m.valid && seg_m.ready) begin
        act_r.status = tps_pkg::status_e'(seg_m.status);
        act_r.pts = {seg_m.start_x, seg_m.start_y, seg_m.start_z,
                     seg_m.end_x, seg_m.end_y, seg_m.end_z};
        act_r.count = seg_m.stored_count;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: segment transaction with none expected", $realtime);
        end else begin
          exp_r = expected_q.pop_front();
          if (act_r.status !== exp_r.status) report("status", exp_r.status, act_r.status);
          for (int k = 0; k < 6; k++)
            if (act_r.pts[5-k] !== exp_r.pts[5-k])
              report(names[k], exp_r.pts[5-k], act_r.pts[5-k]);
          if (act_r.count !== exp_r.count) report("stored_count", exp_r.count, act_r.count);
        end
      end
      if (tri_m.valid && tri_m.ready) begin
        if (tri_m.operation == tps_pkg::OP_CLEAR) begin
          seg_count = 0;
          exp_r = '0;
        end else begin
          verts = '{tri_m.vertex_a_x, tri_m.vertex_a_y, tri_m.vertex_a_z,
                    tri_m.vertex_b_x, tri_m.vertex_b_y, tri_m.vertex_b_z,
                    tri_m.vertex_c_x, tri_m.vertex_c_y, tri_m.vertex_c_z};
          exp_r = slice_triangle(verts);
        end
        expected_q = {expected_q, exp_r};
      end
      pending_o <= expected_q.size();
    end
  end

  assign fail_count_o = mismatches;

  initial mismatches = 0;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench top of the triangle plane slicer: clock, reset, triangle and config stimulus,
// random output stalls and the verdict. Depends on tps_pkg, tps_ifs, triangle_plane_slicer and tps_checker.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] C_MAX = 32'h7fffffff;
  localparam logic [31:0] C_MIN = 32'h80000000;

  typedef struct {
    logic        op;
    logic [31:0] v [9];
  } triangle_t;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   item_idx;
  logic [31:0] plane_org [3];
  triangle_t   history_q [$];

  tps_tri_if tri_if ();
  tps_seg_if seg_if ();
  tps_cfg_if cfg_if ();

  triangle_plane_slicer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tri_i  (tri_if),
    .seg_o  (seg_if),
    .cfg_i  (cfg_if)
  );

  tps_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tri_m        (tri_if),
    .seg_m        (seg_if),
    .cfg_m        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int cyc;
    cyc = 0;
    seg_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 3000 && cyc < 5000) begin
        seg_if.ready <= 1'b0;
      end else if (cyc >= 8000 && cyc < 20000) begin
        seg_if.ready <= 1'b1;
      end else begin
        seg_if.ready <= ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic send(input triangle_t t);
    if (!(item_idx >= 200 && item_idx < 300) && $urandom_range(99) < 14) begin
      tri_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    tri_if.valid <= 1'b1;
    tri_if.operation <= t.op;
    tri_if.vertex_a_x <= t.v[0];
    tri_if.vertex_a_y <= t.v[1];
    tri_if.vertex_a_z <= t.v[2];
    tri_if.vertex_b_x <= t.v[3];
    tri_if.vertex_b_y <= t.v[4];
    tri_if.vertex_b_z <= t.v[5];
    tri_if.vertex_c_x <= t.v[6];
    tri_if.vertex_c_y <= t.v[7];
    tri_if.vertex_c_z <= t.v[8];
    do @(posedge clk_i); while (!tri_if.ready);
    item_idx++;
    if (t.op == tps_pkg::OP_SLICE) begin
      history_q = {history_q, t};
      if (history_q.size() > 40) void'(history_q.pop_front());
    end
  endtask

  task automatic send_tri(input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    triangle_t t;
    t.op = tps_pkg::OP_SLICE;
    t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    send(t);
  endtask

  task automatic send_clear();
    triangle_t t;
    t.op = tps_pkg::OP_CLEAR;
    foreach (t.v[k]) t.v[k] = $urandom();
    send(t);
  endtask

  task automatic drain();
    tri_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [tps_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [31:0] ox, oy, oz, nx, ny, nz, tl);
    drain();
    cfg_write(tps_pkg::REG_ORIGIN_X, ox);
    cfg_write(tps_pkg::REG_ORIGIN_Y, oy);
    cfg_write(tps_pkg::REG_ORIGIN_Z, oz);
    cfg_write(tps_pkg::REG_NORMAL_X, nx);
    cfg_write(tps_pkg::REG_NORMAL_Y, ny);
    cfg_write(tps_pkg::REG_NORMAL_Z, nz);
    cfg_write(tps_pkg::REG_TOL, tl);
    cfg_if.valid <= 1'b0;
    plane_org = '{ox, oy, oz};
  endtask

  function automatic logic [31:0] rand_signed(input int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic random_items(input int n);
    triangle_t t;
    triangle_t h;
    int unsigned span;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      t.op = tps_pkg::OP_SLICE;
      if (sel < 8) begin
        send_clear();
        continue;
      end else if (sel < 28 && history_q.size() > 0) begin
        h = history_q[$urandom_range(history_q.size() - 1)];
        sel = $urandom_range(2);
        for (int k = 0; k < 9; k++) t.v[k] = h.v[(k + 3 * sel) % 9];
      end else if (sel < 38) begin
        foreach (t.v[k]) t.v[k] = $urandom();
      end else begin
        case ($urandom_range(2))
          0: span = 1000;
          1: span = 1000000;
          default: span = 32'h7fffffff;
        endcase
        foreach (t.v[k]) t.v[k] = plane_org[k % 3] + rand_signed(span);
        if ($urandom_range(99) < 15) begin
          sel = $urandom_range(2);
          for (int k = 0; k < 3; k++) t.v[3 * sel + k] = plane_org[k];
        end
      end
      send(t);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    item_idx = 0;
    plane_org = '{32'd0, 32'd0, 32'd0};
    tri_if.valid <= 1'b0;
    tri_if.operation <= tps_pkg::OP_SLICE;
    tri_if.vertex_a_x <= '0;
    tri_if.vertex_a_y <= '0;
    tri_if.vertex_a_z <= '0;
    tri_if.vertex_b_x <= '0;
    tri_if.vertex_b_y <= '0;
    tri_if.vertex_b_z <= '0;
    tri_if.vertex_c_x <= '0;
    tri_if.vertex_c_y <= '0;
    tri_if.vertex_c_z <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= tps_pkg::REG_ORIGIN_X;
    cfg_if.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_clear();
    send_tri(0, 0, 0, 50, 9, 5, -7, 3, -10);
    send_tri(1, 1, 0, 2, 2, 100, 3, 3, 500);
    send_tri(1, 1, 20, 2, 2, 100, 3, 3, 500);
    send_tri(0, 0, -1000, 100, 0, 1000, 0, 100, 3000);
    send_tri(0, 0, -1000, 100, 0, 1000, 0, 100, 3000);
    send_tri(100, 0, 1000, 0, 100, 3000, 0, 0, -1000);
    send_tri(5, 5, 0, 0, 9, -500, 9, 0, 700);
    send_tri(7, 7, 0, 7, 7, 3, 1, 2, 50);
    send_tri(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 0, 0, C_MAX);
    send_tri(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1000, C_MAX, C_MAX, C_MIN);
    send_tri(0, 0, -1000, 1, -1, 1000, 4, 4, 4000);
    send_tri(-3, 3, -1000, -4, 4, 1000, 4, 4, -4000);
    send_tri(8, 8, 10, 9, 9, -11, 6, 6, 11);
    send_tri(8, 8, -10, 9, 9, 11, 6, 6, -11);
    send_tri(1, 2, -300, 3, 4, -400, 5, 6, -500);
    send_clear();
    send_tri(0, 0, -1000, 100, 0, 1000, 0, 100, 3000);

    random_items(100);
    configure(rand_signed(1 << 20), rand_signed(1 << 20), rand_signed(1 << 20),
              rand_signed(65536), rand_signed(65536), rand_signed(65536),
              $urandom_range(100));
    random_items(100);
    configure(C_MAX, C_MIN, 0, -65536, 65536, 65536, 0);
    random_items(100);
    configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              32'hfffff);
    random_items(100);
    configure(C_MIN, C_MIN, C_MAX, 0, 0, -65536, $urandom());
    random_items(80);
    configure(0, 0, 0, 0, 0, 65536, 10);
    random_items(70);

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/tps_pkg.sv
sv/tps_ifs.sv
sv/tps_div.sv
sv/tps_geom.sv
sv/tps_table.sv
sv/triangle_plane_slicer.sv
verif/tps_checker.sv
verif/tb_top.sv
